// ===== rtl/vruntime_run_queue_macros.svh =====
// Assertion macros shared by the run queue RTL.
`ifndef VRUNTIME_RUN_QUEUE_MACROS_SVH
`define VRUNTIME_RUN_QUEUE_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define VRQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define VRQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/vrq_pkg.sv =====
`timescale 1ns / 1ps
package vrq_pkg;

  localparam logic [1:0] K_READY   = 2'd0;
  localparam logic [1:0] K_BLOCK   = 2'd1;
  localparam logic [1:0] K_SUSPEND = 2'd2;
  localparam logic [1:0] K_PICK    = 2'd3;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_READY     = 3'd1,
    ST_RUNNING   = 3'd2,
    ST_BLOCKED   = 3'd3,
    ST_SUSPENDED = 3'd4
  } task_state_t;

endpackage

// ===== rtl/vruntime_run_queue.sv =====
`timescale 1ns / 1ps
// Fair-share run queue kept in a slot memory sorted by wrapping virtual runtime.
// Every request beat gives exactly one result beat. A request that changes no queue
// slot goes straight to the result stage and back to idle. An insert into a non-empty
// queue or a removal walks the queue one slot per cycle through the read and write ports
// of the slot memory; an insert then writes the tail slot. Both then re-read the head to
// update the minimum, unless the queue is left empty, and the result beat may then wait
// on out_stall.
// The next request is taken once the result is in the output register.
`include "vruntime_run_queue_macros.svh"

module vruntime_run_queue
  import vrq_pkg::*;
#(
  parameter int MAX_TASKS    = 32,
  parameter int RUNTIME_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [4:0]  task_id,
  input  logic [63:0] vruntime,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        picked_valid,
  output logic [4:0]  picked_task,
  output logic [63:0] picked_vruntime,
  output logic        state_changed,
  output logic [63:0] min_runtime_out,
  output logic [5:0]  queue_count
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int RB = RUNTIME_BITS;
  localparam logic [RB-1:0] RT_HALF = {1'b0, {(RB-1){1'b1}}};

  typedef struct packed {
    logic [IW-1:0] tsk;
    logic [RB-1:0] key;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_TAIL, S_HEAD_RD, S_HEAD_WT, S_FIN
  } fsm_t;

  function automatic logic lies_before(input logic [RB-1:0] a, input logic [RB-1:0] b);
    logic [RB-1:0] diff;
    diff = a - b;
    return (a != b) && (diff >= RT_HALF);
  endfunction

  fsm_t          state;
  logic [CW-1:0] cnt;
  logic [CW-1:0] idx;
  logic [RB-1:0] min_rt;
  logic [RB-1:0] key;
  logic [IW-1:0] tid;
  logic          op_ins;
  logic          is_pick;
  logic          found;
  entry_t        carry;
  logic          res_pv;
  logic [IW-1:0] res_task;
  logic [RB-1:0] res_key;
  logic          res_chg;
  task_state_t   tstate [MAX_TASKS];

  entry_t        qmem [MAX_TASKS];
  entry_t        rd_data;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [IW-1:0] mem_ra;
  entry_t        mem_wd;

  logic          accept;
  logic [8:0]    tid_w;
  logic          tid_ok;
  logic [IW-1:0] ti;
  logic [RB-1:0] vr;
  logic [RB-1:0] clamped;
  task_state_t   target;
  task_state_t   cur;
  logic          last;
  logic          hit;
  logic          match;
  entry_t        new_ent;
  logic [8:0]    pt_w;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign tid_w    = 9'(task_id);
  assign tid_ok   = tid_w < 9'(MAX_TASKS);
  assign ti       = tid_w[IW-1:0];
  assign vr       = vruntime[RB-1:0];
  assign clamped  = lies_before(vr, min_rt) ? min_rt : vr;
  assign cur      = tstate[ti];
  assign last     = (idx == cnt - CW'(1));
  assign new_ent  = '{tsk: tid, key: key};
  assign hit      = !found && lies_before(key, rd_data.key);
  assign match    = is_pick ? (idx == '0) : (rd_data.tsk == tid);

  always_comb begin
    case (kind)
      K_READY: target = ST_READY;
      K_BLOCK: target = ST_BLOCKED;
      default: target = ST_SUSPENDED;
    endcase
  end

  // Memory port control: read slot idx + 1 while an insert writes slot idx or a removal writes slot idx - 1.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx[IW-1:0];
    mem_wd = carry;
    mem_ra = '0;
    case (state)
      S_SCAN: begin
        mem_ra = IW'(idx + CW'(1));
        if (op_ins) begin
          mem_we = hit || found;
          mem_wd = hit ? new_ent : carry;
        end else begin
          mem_we = found;
          mem_wa = IW'(idx - CW'(1));
          mem_wd = rd_data;
        end
      end
      S_TAIL: begin
        mem_we = 1'b1;
        mem_wa = cnt[IW-1:0];
        mem_wd = found ? carry : new_ent;
      end
      default: begin
        mem_ra = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      qmem[mem_wa] <= mem_wd;
    end
    rd_data <= qmem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      min_rt    <= '0;
      out_valid <= 1'b0;
      found     <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        tstate[i] <= ST_NEW;
      end
    end else begin
      // In S_FIN the output register is reloaded instead of cleared.
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_pv   <= 1'b0;
            res_task <= '0;
            res_key  <= '0;
            res_chg  <= 1'b0;
            found    <= 1'b0;
            idx      <= '0;
            tid      <= ti;
            key      <= clamped;
            is_pick  <= (kind == K_PICK);
            op_ins   <= 1'b0;
            state    <= S_FIN;
            if (kind == K_PICK) begin
              if (cnt != '0) begin
                res_chg <= 1'b1;
                state   <= S_SCAN;
              end
            end else if (tid_ok && cur != target) begin
              if (target == ST_READY) begin
                if (cnt < CW'(MAX_TASKS)) begin
                  op_ins     <= 1'b1;
                  res_chg    <= 1'b1;
                  tstate[ti] <= ST_READY;
                  state      <= (cnt == '0) ? S_TAIL : S_SCAN;
                end
              end else begin
                res_chg    <= 1'b1;
                tstate[ti] <= target;
                if (cur == ST_READY) begin
                  state <= S_SCAN;
                end
              end
            end
          end
        end
        S_SCAN: begin
          if (op_ins) begin
            if (hit || found) begin
              found <= 1'b1;
              carry <= rd_data;
            end
            if (last) begin
              state <= S_TAIL;
            end
          end else begin
            if (match) begin
              found <= 1'b1;
            end
            if (is_pick && idx == '0) begin
              res_pv               <= 1'b1;
              res_task             <= rd_data.tsk;
              res_key              <= rd_data.key;
              tstate[rd_data.tsk]  <= ST_RUNNING;
            end
            if (last) begin
              cnt   <= cnt - CW'(1);
              state <= S_HEAD_RD;
            end
          end
          idx <= idx + CW'(1);
        end
        S_TAIL: begin
          cnt   <= cnt + CW'(1);
          state <= S_HEAD_RD;
        end
        S_HEAD_RD: begin
          state <= (cnt != '0) ? S_HEAD_WT : S_FIN;
        end
        S_HEAD_WT: begin
          min_rt <= rd_data.key;
          state  <= S_FIN;
        end
        S_FIN: begin
          // The result beat waits here until the output register is free.
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            picked_valid    <= res_pv;
            picked_task     <= pt_w[4:0];
            picked_vruntime <= 64'(res_key);
            state_changed   <= res_chg;
            min_runtime_out <= 64'(min_rt);
            queue_count     <= 6'(cnt);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign pt_w = 9'(res_task);

  `VRQ_ASSERT_NEVER(a_cnt_bound, cnt > CW'(MAX_TASKS), "queue count beyond capacity")
  `VRQ_ASSERT_IMP(a_pick_changes, out_valid && picked_valid, state_changed, "pick without change")
  `VRQ_ASSERT_IMP(a_tail_room, state == S_TAIL, cnt < CW'(MAX_TASKS), "insert into full queue")
  `VRQ_ASSERT_IMP(a_scan_busy, state == S_SCAN, cnt != '0, "scan of an empty queue")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import vrq_pkg::*;

  localparam int NTASK = 32;
  localparam logic [63:0] HALF = 64'hFFFF_FFFF_FFFF_FFFF / 2;

  typedef struct packed {
    logic        pv;
    logic [4:0]  ptask;
    logic [63:0] pkey;
    logic        changed;
    logic [63:0] minv;
    logic [5:0]  cnt;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = K_READY;
  logic [4:0] task_id = '0;
  logic [63:0] vruntime = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic picked_valid;
  logic [4:0] picked_task;
  logic [63:0] picked_vruntime;
  logic state_changed;
  logic [63:0] min_runtime_out;
  logic [5:0] queue_count;

  vruntime_run_queue DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .task_id(task_id), .vruntime(vruntime),
    .out_valid(out_valid), .out_stall(out_stall),
    .picked_valid(picked_valid), .picked_task(picked_task),
    .picked_vruntime(picked_vruntime), .state_changed(state_changed),
    .min_runtime_out(min_runtime_out), .queue_count(queue_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Software copy of the scheduler state.
  logic [4:0]  slot_task [NTASK];
  logic [63:0] slot_key [NTASK];
  int unsigned n_queued;
  task_state_t tstate [NTASK];
  logic [63:0] min_rt;

  sched_result_t pending_results[$];
  int errors = 0;
  bit stall_free = 1'b0;

  function automatic bit earlier(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    return (a != b) && (d >= HALF);
  endfunction

  function automatic void remove_slot(int unsigned pos);
    for (int unsigned i = pos; i + 1 < n_queued; i++) begin
      slot_task[i] = slot_task[i + 1];
      slot_key[i] = slot_key[i + 1];
    end
    n_queued--;
  endfunction

  function automatic sched_result_t schedule(logic [1:0] k, logic [4:0] t,
                                             logic [63:0] vr);
    sched_result_t r;
    task_state_t target;
    int unsigned pos;
    logic [63:0] key;
    r = '0;
    if (k == K_PICK) begin
      if (n_queued > 0) begin
        r.pv = 1'b1;
        r.ptask = slot_task[0];
        r.pkey = slot_key[0];
        remove_slot(0);
        if (n_queued > 0) min_rt = slot_key[0];
        tstate[r.ptask] = ST_RUNNING;
        r.changed = 1'b1;
      end
    end else begin
      target = (k == K_READY) ? ST_READY : (k == K_BLOCK) ? ST_BLOCKED : ST_SUSPENDED;
      if (tstate[t] != target) begin
        if (target == ST_READY) begin
          key = earlier(vr, min_rt) ? min_rt : vr;
          pos = 0;
          while (pos < n_queued && !earlier(key, slot_key[pos])) pos++;
          for (int unsigned i = n_queued; i > pos; i--) begin
            slot_task[i] = slot_task[i - 1];
            slot_key[i] = slot_key[i - 1];
          end
          slot_task[pos] = t;
          slot_key[pos] = key;
          n_queued++;
          min_rt = slot_key[0];
        end else if (tstate[t] == ST_READY) begin
          for (int unsigned i = 0; i < n_queued; i++)
            if (slot_task[i] == t) begin
              remove_slot(i);
              break;
            end
          if (n_queued > 0) min_rt = slot_key[0];
        end
        tstate[t] = target;
        r.changed = 1'b1;
      end
    end
    r.minv = min_rt;
    r.cnt = n_queued[5:0];
    return r;
  endfunction

  // Valid stays high across a zero gap so that back-to-back beats never see two
  // assignments to it in one time step.
  task automatic send_request(logic [1:0] k, logic [4:0] t, logic [63:0] vr);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    task_id <= t;
    vruntime <= vr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(schedule(k, t, vr));
  endtask

  // Receiver stall: a fresh wait drawn for every result beat.
  initial begin
    int wait_n;
    @(negedge rst);
    forever begin
      wait_n = (stall_free || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    sched_result_t e;
    sched_result_t a;
    if (!rst && out_valid && !out_stall) begin
      a = '{picked_valid, picked_task, picked_vruntime, state_changed,
            min_runtime_out, queue_count};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, a);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (e.pv != a.pv) begin
          $display("%0t: picked_valid exp %0d got %0d", $time, e.pv, a.pv); errors++;
        end
        if (e.ptask != a.ptask) begin
          $display("%0t: picked_task exp %0d got %0d", $time, e.ptask, a.ptask); errors++;
        end
        if (e.pkey != a.pkey) begin
          $display("%0t: picked_vruntime exp %h got %h", $time, e.pkey, a.pkey); errors++;
        end
        if (e.changed != a.changed) begin
          $display("%0t: state_changed exp %0d got %0d", $time, e.changed, a.changed);
          errors++;
        end
        if (e.minv != a.minv) begin
          $display("%0t: min_runtime_out exp %h got %h", $time, e.minv, a.minv); errors++;
        end
        if (e.cnt != a.cnt) begin
          $display("%0t: queue_count exp %0d got %0d", $time, e.cnt, a.cnt); errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_request(K_PICK, 5'd0, 64'd0);
    send_request(K_BLOCK, 5'd3, 64'd0);
    send_request(K_BLOCK, 5'd3, 64'd0);
    send_request(K_READY, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(K_READY, 5'd31, 64'd0);
    send_request(K_READY, 5'd31, 64'd5);
    send_request(K_READY, 5'd1, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(K_READY, 5'd2, 64'h8000_0000_0000_0000);
    send_request(K_READY, 5'd4, 64'd0);
    send_request(K_SUSPEND, 5'd31, 64'd0);
    send_request(K_SUSPEND, 5'd31, 64'd0);
    send_request(K_BLOCK, 5'd1, 64'd0);
    send_request(K_PICK, 5'd17, 64'd0);
    send_request(K_PICK, 5'd0, 64'd0);
    send_request(K_PICK, 5'd0, 64'd0);
    send_request(K_PICK, 5'd0, 64'd0);
    send_request(K_READY, 5'd1, 64'd0);
    send_request(K_SUSPEND, 5'd1, 64'd0);
    send_request(K_PICK, 5'd0, 64'd0);
  endtask

  task automatic test_fill_and_drain();
    logic [63:0] base;
    base = rand64();
    for (int i = 0; i < NTASK; i++)
      send_request(K_READY, i[4:0], base + 64'($urandom_range(0, 3)));
    send_request(K_READY, 5'd7, base);
    stall_free = 1'b1;
    wait_drained();
    stall_free = 1'b0;
    for (int i = 0; i < NTASK + 1; i++) send_request(K_PICK, 5'd0, 64'd0);
  endtask

  task automatic test_random();
    logic [1:0] k;
    logic [63:0] vr;
    for (int n = 0; n < 460; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: k = K_READY;
        4: k = K_BLOCK;
        5: k = K_SUSPEND;
        default: k = K_PICK;
      endcase
      case ($urandom_range(0, 3))
        0: vr = rand64();
        1: vr = min_rt + 64'($urandom_range(0, 8));
        2: vr = min_rt - 64'($urandom_range(0, 8));
        default: vr = min_rt + {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, $urandom};
      endcase
      send_request(k, 5'($urandom), vr);
      if (n == 230) wait_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < NTASK; i++) tstate[i] = ST_NEW;
    n_queued = 0;
    min_rt = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_and_drain();
    test_random();
    wait_drained();
    repeat (60) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end
endmodule
